[rtl/rgbhsl_pkg.sv]
// Package for the RGB to HSL converter: widths, hue sector codes and the divider step.
`timescale 1ns / 1ps

package rgbhsl_pkg;

  // Field widths of the pixel and of the result.
  localparam int CHAN_W = 8;
  localparam int HUE_W  = 15;
  localparam int SAT_W  = 16;
  localparam int LSUM_W = 9;

  // Width of the hue numerator, which stays below six times the channel difference.
  localparam int NUM_W = 11;

  // Conversion constants.
  localparam int CHAN_MAX      = 255;
  localparam int HUE_SCALE     = 60;
  localparam int HUE_DEG_FULL  = 360;
  localparam int HUE_WRAP_MUL  = 6;
  localparam int GREEN_OFS_MUL = 2;
  localparam int BLUE_OFS_MUL  = 4;
  localparam int SAT_FIELD_MAX = 65535;

  // Which channel holds the largest value.
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  // One restoring division step: shift the next dividend bit into the partial
  // remainder and subtract the divisor when it fits. Returns {remainder, quotient bit}.
  function automatic logic [CHAN_W:0] div_step(input logic [CHAN_W-1:0] rem,
                                               input logic              nb,
                                               input logic [CHAN_W-1:0] dvs);
    logic [CHAN_W:0] t;
    logic [CHAN_W:0] diff;
    t    = {rem, nb};
    diff = t - {1'b0, dvs};
    if (t >= {1'b0, dvs}) begin
      return {diff[CHAN_W-1:0], 1'b1};
    end else begin
      return {t[CHAN_W-1:0], 1'b0};
    end
  endfunction

endpackage

[rtl/rgb_to_hsl.sv]
// Pipelined RGB to HSL converter for pixels with 8-bit channels.
`timescale 1ns / 1ps

// Usage:
// An RGB pixel enters on the s_axis channel and leaves as HSL on m_axis.
// Hue is in units of 2^-HUE_FRAC_BITS degree in [0, 360), saturation is an
// unsigned fraction with SAT_FRAC_BITS fraction bits limited to 65535, and
// the lightness field is max + min channel (lightness = value / 510).
// A gray pixel gives hue 0 and saturation 0.
// Throughput is one item per clock unless the receiver stalls. Each item
// passes the front stages, the NS divider stages and the output register,
// where NS = max(clog2(360 * 2^HUE_FRAC_BITS), SAT_FRAC_BITS + 1) is the
// number of stages of the two restoring dividers, one quotient bit per stage.
// Four stages in front find the largest and smallest channel, the sector,
// the difference and the dividends.
// Reset clears all valid bits; no item is in flight afterwards.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready drops; no item is lost or repeated.
module rgb_to_hsl
  import rgbhsl_pkg::*;
#(
  parameter int HUE_FRAC_BITS = 6,
  parameter int SAT_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // hue [14:0], saturation [30:15], lightness_sum [39:31]
);

  // Divider sizing.
  localparam int HueQW  = $clog2(HUE_DEG_FULL << HUE_FRAC_BITS);
  localparam int SatQW  = SAT_FRAC_BITS + 1;
  localparam int NS     = (HueQW > SatQW) ? HueQW : SatQW;
  localparam int XW     = NS + CHAN_W;
  localparam int SatLimInt = (SAT_FRAC_BITS >= SAT_W) ? SAT_FIELD_MAX
                                                     : ((1 << SAT_FRAC_BITS) - 1);
  localparam logic [NS-1:0] SatLim = NS'(SatLimInt);

  // The whole pipeline moves when the output register is free or being taken.
  logic en;
  logic out_vld_q;
  assign en            = ~out_vld_q | m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: capture the pixel.
  logic              v1_q;
  logic [CHAN_W-1:0] r1_q, g1_q, b1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_q <= s_axis_tdata[7:0];
      g1_q <= s_axis_tdata[15:8];
      b1_q <= s_axis_tdata[23:16];
    end
  end

  // Stage 2: largest and smallest channel; red wins ties over green, green over blue.
  logic              v2_q;
  logic [CHAN_W-1:0] r2_q, g2_q, b2_q, mx2_q, mn2_q;
  sector_e           sec2_q;
  logic [CHAN_W-1:0] mx2_d, mn2_d;
  sector_e           sec2_d;

  always_comb begin
    priority if (r1_q >= g1_q && r1_q >= b1_q) begin
      sec2_d = SEC_RED;
      mx2_d  = r1_q;
    end else if (g1_q >= b1_q) begin
      sec2_d = SEC_GREEN;
      mx2_d  = g1_q;
    end else begin
      sec2_d = SEC_BLUE;
      mx2_d  = b1_q;
    end
    if (r1_q <= g1_q && r1_q <= b1_q) begin
      mn2_d = r1_q;
    end else if (g1_q <= b1_q) begin
      mn2_d = g1_q;
    end else begin
      mn2_d = b1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_q   <= r1_q;
      g2_q   <= g1_q;
      b2_q   <= b1_q;
      mx2_q  <= mx2_d;
      mn2_q  <= mn2_d;
      sec2_q <= sec2_d;
    end
  end

  // Stage 3: difference, sum, saturation denominator and hue numerator.
  logic              v3_q, gray3_q;
  logic [LSUM_W-1:0] lsum3_q;
  logic [CHAN_W-1:0] d3_q, den3_q;
  logic [NUM_W-1:0]  n3_q;
  logic [CHAN_W-1:0] d3_d, den3_d;
  logic [LSUM_W-1:0] s3_d;
  logic [NUM_W-1:0]  n3_d;

  always_comb begin
    d3_d = mx2_q - mn2_q;
    s3_d = LSUM_W'(mx2_q) + LSUM_W'(mn2_q);
    // 255 - |s - 255|
    if (s3_d > LSUM_W'(CHAN_MAX)) begin
      den3_d = CHAN_W'(LSUM_W'(2 * CHAN_MAX) - s3_d);
    end else begin
      den3_d = s3_d[CHAN_W-1:0];
    end
    // Numerator in units of d; modular arithmetic gives the non-negative result.
    unique case (sec2_q)
      SEC_RED: begin
        if (g2_q >= b2_q) begin
          n3_d = NUM_W'(g2_q) - NUM_W'(b2_q);
        end else begin
          n3_d = NUM_W'(d3_d) * NUM_W'(HUE_WRAP_MUL) + NUM_W'(g2_q) - NUM_W'(b2_q);
        end
      end
      SEC_GREEN: n3_d = NUM_W'(d3_d) * NUM_W'(GREEN_OFS_MUL) + NUM_W'(b2_q) - NUM_W'(r2_q);
      SEC_BLUE:  n3_d = NUM_W'(d3_d) * NUM_W'(BLUE_OFS_MUL) + NUM_W'(r2_q) - NUM_W'(g2_q);
      default:   n3_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gray3_q <= (d3_d == '0);
      lsum3_q <= s3_d;
      d3_q    <= d3_d;
      den3_q  <= den3_d;
      n3_q    <= n3_d;
    end
  end

  // Stage 4: dividends for hue (60 * N scaled) and saturation (d scaled).
  logic              v4_q, gray4_q;
  logic [LSUM_W-1:0] lsum4_q;
  logic [CHAN_W-1:0] d4_q, den4_q;
  logic [XW-1:0]     hdvd4_q, sdvd4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gray4_q <= gray3_q;
      lsum4_q <= lsum3_q;
      d4_q    <= d3_q;
      den4_q  <= den3_q;
      hdvd4_q <= (XW'(n3_q) * XW'(HUE_SCALE)) << HUE_FRAC_BITS;
      sdvd4_q <= XW'(d3_q) << SAT_FRAC_BITS;
    end
  end

  // Division stages: each one produces one quotient bit of both dividers.
  // The partial remainder sits beside a shift register that feeds dividend bits
  // out at the top and takes quotient bits in at the bottom.
  logic              dv_q    [NS];
  logic              dgray_q [NS];
  logic [LSUM_W-1:0] dlsum_q [NS];
  logic [CHAN_W-1:0] dd_q    [NS];
  logic [CHAN_W-1:0] dden_q  [NS];
  logic [CHAN_W-1:0] hrem_q  [NS];
  logic [NS-1:0]     hx_q    [NS];
  logic [CHAN_W-1:0] srem_q  [NS];
  logic [NS-1:0]     sx_q    [NS];

  for (genvar k = 0; k < NS; k++) begin : g_div
    logic              v_src, gray_src;
    logic [LSUM_W-1:0] lsum_src;
    logic [CHAN_W-1:0] d_src, den_src, hrem_src, srem_src;
    logic [NS-1:0]     hx_src, sx_src;
    logic [CHAN_W:0]   hstep, sstep;

    if (k == 0) begin : g_first
      assign v_src    = v4_q;
      assign gray_src = gray4_q;
      assign lsum_src = lsum4_q;
      assign d_src    = d4_q;
      assign den_src  = den4_q;
      assign hrem_src = hdvd4_q[XW-1 -: CHAN_W];
      assign hx_src   = hdvd4_q[NS-1:0];
      assign srem_src = sdvd4_q[XW-1 -: CHAN_W];
      assign sx_src   = sdvd4_q[NS-1:0];
    end else begin : g_next
      assign v_src    = dv_q[k-1];
      assign gray_src = dgray_q[k-1];
      assign lsum_src = dlsum_q[k-1];
      assign d_src    = dd_q[k-1];
      assign den_src  = dden_q[k-1];
      assign hrem_src = hrem_q[k-1];
      assign hx_src   = hx_q[k-1];
      assign srem_src = srem_q[k-1];
      assign sx_src   = sx_q[k-1];
    end

    assign hstep = div_step(hrem_src, hx_src[NS-1], d_src);
    assign sstep = div_step(srem_src, sx_src[NS-1], den_src);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (en) begin
        dv_q[k] <= v_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dgray_q[k] <= gray_src;
        dlsum_q[k] <= lsum_src;
        dd_q[k]    <= d_src;
        dden_q[k]  <= den_src;
        hrem_q[k]  <= hstep[CHAN_W:1];
        hx_q[k]    <= {hx_src[NS-2:0], hstep[0]};
        srem_q[k]  <= sstep[CHAN_W:1];
        sx_q[k]    <= {sx_src[NS-2:0], sstep[0]};
      end
    end
  end

  // Output register: clamp saturation, zero a gray pixel.
  logic [HUE_W-1:0]  hue_q;
  logic [SAT_W-1:0]  sat_q;
  logic [LSUM_W-1:0] lsum_q;
  logic [NS-1:0]     sat_lim;

  assign sat_lim = (sx_q[NS-1] > SatLim) ? SatLim : sx_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lsum_q <= dlsum_q[NS-1];
      if (dgray_q[NS-1]) begin
        hue_q <= '0;
        sat_q <= '0;
      end else begin
        hue_q <= HUE_W'(hx_q[NS-1]);
        sat_q <= SAT_W'(sat_lim);
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {lsum_q, sat_q, hue_q};

endmodule
